@@ src/utad_pkg.sv @@
// Shared types and constants for the unsigned-to-ASCII digit converter.
`default_nettype none

package utad_pkg;

  // Radix command codes; the unused code falls back to decimal.
  localparam logic [1:0] CMD_DEC = 2'd0;
  localparam logic [1:0] CMD_HEX = 2'd1;
  localparam logic [1:0] CMD_BIN = 2'd2;

  localparam logic [6:0] ASCII_ZERO = 7'h30;
  localparam logic [6:0] ASCII_A    = 7'h41;

  // Input item: radix command and the number to print.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] value;
  } num_item_t;

  // Output item: one character of the printed number.
  typedef struct packed {
    logic [6:0] digit_char;
    logic       last;
  } txt_item_t;

  // Front to buffer: digit write and end-of-number push.
  typedef struct packed {
    logic       wr_en;
    logic [3:0] digit;
    logic       push;
  } front_wr_t;

  // Back to buffer: digit read and release of the finished number.
  typedef struct packed {
    logic rd_en;
    logic pop;
  } back_req_t;

  // Buffer fill status seen by both sides.
  typedef struct packed {
    logic full;
    logic nonempty;
  } buf_status_t;

endpackage

`default_nettype wire

@@ src/utad_front.sv @@
// Front end: accepts a number and finds its digits, least significant first.
`default_nettype none

module utad_front
  import utad_pkg::*;
#(
  parameter int MAX_DIGITS  = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   num_valid,
  output logic                                        num_stall,
  input  wire num_item_t                              num,
  input  wire buf_status_t                            status,
  output front_wr_t                                   wr,
  output logic [$clog2(MAX_DIGITS)-1:0]               wr_idx,
  output logic [$clog2(MAX_DIGITS+1)-1:0]             push_count
);

  localparam int EW    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int PW    = EW + 32;

  // x / 10 == (x * 0xCCCCCCCD) >> 35 for every x below 2**32.
  localparam logic [31:0] DIV10_MULT  = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIG  = 2'd2;

  logic [1:0]       state;
  logic [1:0]       radix;
  logic [EW-1:0]    x;
  logic [CNT_W-1:0] cnt;
  logic [PW-1:0]    prod;

  logic             accept;
  logic [EW-1:0]    q;
  logic [EW-1:0]    rem_full;
  logic [3:0]       digit;
  logic [CNT_W-1:0] cnt_inc;
  logic             done;

  assign num_stall = (state != ST_IDLE) || status.full;
  assign accept    = num_valid && !num_stall;

  always_comb begin
    rem_full = '0;
    case (radix)
      CMD_HEX: begin
        q     = x >> 4;
        digit = x[3:0];
      end
      CMD_BIN: begin
        q     = x >> 1;
        digit = {3'b000, x[0]};
      end
      default: begin
        q        = EW'(prod >> DIV10_SHIFT);
        rem_full = x - (q << 3) - (q << 1);
        digit    = rem_full[3:0];
      end
    endcase
  end

  assign cnt_inc = cnt + CNT_W'(1);
  assign done    = (q == '0) || (cnt_inc == CNT_W'(MAX_DIGITS));

  assign wr.wr_en   = (state == ST_DIG);
  assign wr.digit   = digit;
  assign wr.push    = (state == ST_DIG) && done;
  assign wr_idx     = cnt[IDX_W-1:0];
  assign push_count = cnt_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt <= '0;
            if (num.cmd == CMD_HEX || num.cmd == CMD_BIN) begin
              state <= ST_DIG;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state <= ST_DIG;
        end
        ST_DIG: begin
          if (done) begin
            state <= ST_IDLE;
          end else begin
            cnt   <= cnt_inc;
            state <= (radix == CMD_HEX || radix == CMD_BIN) ? ST_DIG : ST_MUL;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      x <= num.value[EW-1:0];
      if (num.cmd == CMD_HEX || num.cmd == CMD_BIN) begin
        radix <= num.cmd;
      end else begin
        radix <= CMD_DEC;
      end
    end else if (state == ST_DIG && !done) begin
      x <= q;
    end
    if (state == ST_MUL) begin
      prod <= {32'b0, x} * {{EW{1'b0}}, DIV10_MULT};
    end
  end

endmodule

`default_nettype wire

@@ src/utad_buffer.sv @@
// Two-slot digit buffer: one digit memory, half per slot, and a count queue.
`default_nettype none

module utad_buffer
  import utad_pkg::*;
#(
  parameter int MAX_DIGITS = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire front_wr_t                              wr,
  input  wire logic [$clog2(MAX_DIGITS)-1:0]          wr_idx,
  input  wire logic [$clog2(MAX_DIGITS+1)-1:0]        push_count,
  input  wire back_req_t                              req,
  input  wire logic [$clog2(MAX_DIGITS)-1:0]          rd_idx,
  output logic [3:0]                                  rd_digit,
  output buf_status_t                                 status,
  output logic [$clog2(MAX_DIGITS+1)-1:0]             head_count
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int DEPTH = 2 * (2 ** IDX_W);

  logic [3:0]       mem [DEPTH];
  logic [CNT_W-1:0] counts [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       fill;

  assign status.full     = (fill == 2'd2);
  assign status.nonempty = (fill != 2'd0);
  assign head_count      = counts[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr.push) begin
        wptr <= !wptr;
      end
      if (req.pop) begin
        rptr <= !rptr;
      end
      if (wr.push && !req.pop) begin
        fill <= fill + 2'd1;
      end else if (req.pop && !wr.push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) begin
      counts[wptr] <= push_count;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      mem[{wptr, wr_idx}] <= wr.digit;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_digit <= mem[{rptr, rd_idx}];
    end
  end

endmodule

`default_nettype wire

@@ src/utad_back.sv @@
// Back end: reads a number's digits most significant first and sends characters.
`default_nettype none

module utad_back
  import utad_pkg::*;
#(
  parameter int MAX_DIGITS = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire buf_status_t                            status,
  input  wire logic [$clog2(MAX_DIGITS+1)-1:0]        head_count,
  input  wire logic [3:0]                             rd_digit,
  output back_req_t                                   req,
  output logic [$clog2(MAX_DIGITS)-1:0]               rd_idx,
  output logic                                        txt_valid,
  input  wire logic                                   txt_stall,
  output txt_item_t                                   txt
);

  localparam int IDX_W = $clog2(MAX_DIGITS);

  function automatic logic [6:0] to_ascii(input logic [3:0] d);
    if (d < 4'd10) begin
      return ASCII_ZERO + {3'b000, d};
    end else begin
      return ASCII_A + {3'b000, d} - 7'd10;
    end
  endfunction

  logic             active;
  logic [IDX_W-1:0] idx;
  logic             rd_valid;
  logic             rd_last;

  logic             out_free;
  logic             move;
  logic             rd_free;
  logic             issue;

  assign out_free = !txt_valid || !txt_stall;
  assign move     = rd_valid && out_free;
  assign rd_free  = !rd_valid || move;
  assign issue    = active && rd_free;

  assign req.rd_en = issue;
  assign req.pop   = issue && (idx == '0);
  assign rd_idx    = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      rd_valid  <= 1'b0;
      txt_valid <= 1'b0;
    end else begin
      if (!active && status.nonempty) begin
        active <= 1'b1;
      end else if (issue && idx == '0) begin
        active <= 1'b0;
      end

      if (issue) begin
        rd_valid <= 1'b1;
      end else if (move) begin
        rd_valid <= 1'b0;
      end

      if (move) begin
        txt_valid <= 1'b1;
      end else if (!txt_stall) begin
        txt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!active && status.nonempty) begin
      idx <= IDX_W'(head_count - 1'b1);
    end else if (issue && idx != '0) begin
      idx <= idx - 1'b1;
    end
    if (issue) begin
      rd_last <= (idx == '0);
    end
    if (move) begin
      txt.digit_char <= to_ascii(rd_digit);
      txt.last       <= rd_last;
    end
  end

endmodule

`default_nettype wire

@@ src/unsigned_to_ascii_digits_core.sv @@
// Top level of the unsigned-to-ASCII digit converter.
//
//   channel   signals                      item
//   num       num_valid / num_stall / num  radix command and 32-bit value
//   txt       txt_valid / txt_stall / txt  one ASCII character, last flag
//
// The front finds each decimal digit by a reciprocal multiply, then a
// remainder step, and each hex or binary digit by a shift alone. The back
// sends one character a cycle while txt is not stalled, and opens each
// number before its first digit read. Two converted numbers can wait in the
// buffer; the front stalls num while it converts or while both slots are full.
// Reset clears all control state; the digit memory is not cleared.
`default_nettype none

module unsigned_to_ascii_digits_core
  import utad_pkg::*;
#(
  parameter int MAX_DIGITS  = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      num_valid,
  output logic           num_stall,
  input  wire num_item_t num,
  output logic           txt_valid,
  input  wire logic      txt_stall,
  output txt_item_t      txt
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  front_wr_t        wr;
  logic [IDX_W-1:0] wr_idx;
  logic [CNT_W-1:0] push_count;
  back_req_t        req;
  logic [IDX_W-1:0] rd_idx;
  logic [3:0]       rd_digit;
  buf_status_t      status;
  logic [CNT_W-1:0] head_count;

  utad_front #(
    .MAX_DIGITS  (MAX_DIGITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .num_valid  (num_valid),
    .num_stall  (num_stall),
    .num        (num),
    .status     (status),
    .wr         (wr),
    .wr_idx     (wr_idx),
    .push_count (push_count)
  );

  utad_buffer #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_buffer (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .wr_idx     (wr_idx),
    .push_count (push_count),
    .req        (req),
    .rd_idx     (rd_idx),
    .rd_digit   (rd_digit),
    .status     (status),
    .head_count (head_count)
  );

  utad_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .status     (status),
    .head_count (head_count),
    .rd_digit   (rd_digit),
    .req        (req),
    .rd_idx     (rd_idx),
    .txt_valid  (txt_valid),
    .txt_stall  (txt_stall),
    .txt        (txt)
  );

endmodule

`default_nettype wire

@@ dv/tb_unsigned_to_ascii_digits_core.sv @@
// Self-checking testbench for the unsigned-to-ASCII digit converter core.
module tb_unsigned_to_ascii_digits_core;
  import utad_pkg::*;

  // The spare radix code is not named in the package; the block treats it as decimal.
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int RANDOM_NUMBERS  = 445;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int TAIL_CYCLES     = 40;

  // Expected text for a directed number, right-justified; all zero means predict it.
  typedef logic [8*32-1:0] text_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] value;
    text_t       text;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{CMD_DEC,   32'd0,          "0"},
    '{CMD_HEX,   32'd0,          "0"},
    '{CMD_BIN,   32'd0,          "0"},
    '{CMD_SPARE, 32'd0,          "0"},
    '{CMD_DEC,   32'hFFFF_FFFF,  "4294967295"},
    '{CMD_HEX,   32'hFFFF_FFFF,  "FFFFFFFF"},
    '{CMD_BIN,   32'hFFFF_FFFF,  "11111111111111111111111111111111"},
    '{CMD_SPARE, 32'hFFFF_FFFF,  "4294967295"},
    '{CMD_DEC,   32'd1,          "1"},
    '{CMD_HEX,   32'd1,          "1"},
    '{CMD_BIN,   32'd1,          "1"},
    '{CMD_DEC,   32'd9,          "9"},
    '{CMD_DEC,   32'd10,         "10"},
    '{CMD_HEX,   32'd10,         "A"},
    '{CMD_HEX,   32'd15,         "F"},
    '{CMD_HEX,   32'd16,         "10"},
    '{CMD_BIN,   32'd2,          "10"},
    '{CMD_HEX,   32'hABCD_EF01,  "ABCDEF01"},
    '{CMD_DEC,   32'd1000000000, "1000000000"},
    '{CMD_BIN,   32'h8000_0000,  ""},
    '{CMD_HEX,   32'h7FFF_FFFF,  ""},
    '{CMD_DEC,   32'd999999999,  ""},
    '{CMD_SPARE, 32'd12345,      ""},
    '{CMD_DEC,   32'hAAAA_AAAA,  ""},
    '{CMD_BIN,   32'h5555_5555,  ""}
  };

  logic      clk;
  logic      rst;
  logic      num_valid;
  logic      num_stall;
  num_item_t num;
  logic      txt_valid;
  logic      txt_stall;
  txt_item_t txt;

  num_item_t pending_nums[$];
  text_t     pending_texts[$];
  txt_item_t expected_chars[$];

  int numbers_accepted = 0;
  int chars_checked    = 0;
  int mismatches       = 0;
  int stuck_cycles     = 0;
  bit holding_off      = 0;
  bit hold_done        = 0;

  unsigned_to_ascii_digits_core dut (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_stall (num_stall),
    .num       (num),
    .txt_valid (txt_valid),
    .txt_stall (txt_stall),
    .txt       (txt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Divide down by the radix, then emit the digits most significant first.
  function automatic void predict_digits(input num_item_t item);
    logic [3:0]  digits [32];
    logic [31:0] rest;
    logic [31:0] radix;
    logic [6:0]  d;
    int          n;
    int          k;
    radix = (item.cmd == CMD_HEX) ? 32'd16 : (item.cmd == CMD_BIN) ? 32'd2 : 32'd10;
    rest  = item.value;
    n     = 0;
    do begin
      digits[n] = 4'(rest % radix);
      rest      = rest / radix;
      n++;
    end while (rest != 0 && n < 32);
    for (k = n - 1; k >= 0; k--) begin
      d = 7'(digits[k]);
      expected_chars.push_back('{(d < 7'd10) ? 7'(ASCII_ZERO + d) : 7'(ASCII_A + d - 7'd10),
                                 k == 0});
    end
  endfunction

  function automatic void expect_text(input text_t text);
    logic [7:0] ch;
    int         k;
    for (k = 31; k >= 0; k--) begin
      ch = text[8*k +: 8];
      if (ch != 8'd0) expected_chars.push_back('{ch[6:0], k == 0});
    end
  endfunction

  function automatic logic [1:0] random_cmd();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return CMD_DEC;
    if (r < 6) return CMD_HEX;
    if (r < 9) return CMD_BIN;
    return CMD_SPARE;
  endfunction

  // Mix of full-range values, short numbers and values on digit-count boundaries.
  function automatic logic [31:0] random_value();
    logic [31:0] p;
    int          k;
    case ($urandom_range(0, 5))
      1: return 32'($urandom_range(0, 40));
      2: return $urandom >> $urandom_range(0, 31);
      3: return (32'd1 << $urandom_range(0, 31)) - 32'($urandom_range(0, 1));
      4: begin
        p = 32'd1;
        k = $urandom_range(0, 9);
        repeat (k) p = p * 32'd10;
        return p - 32'($urandom_range(0, 1));
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_gap(input int mode);
    int r;
    if (holding_off || mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (mode == 1) r = r / 2;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Output side: checks every character against the oldest expectation.
  always @(posedge clk) begin
    txt_item_t want;
    if (!rst) begin
      if (txt_valid && !txt_stall) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: unexpected character %h ('%c') last=%b", txt.digit_char,
                     txt.digit_char, txt.last);
        end else begin
          want = expected_chars.pop_front();
          if (txt.digit_char !== want.digit_char || txt.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Mismatch at character %0d: expected %h ('%c') last=%b, ",
                        "got %h ('%c') last=%b"},
                       chars_checked, want.digit_char, want.digit_char, want.last,
                       txt.digit_char, txt.digit_char, txt.last);
          end
        end
      end
      if ((num_valid && !num_stall) || (txt_valid && !txt_stall)) stuck_cycles = 0;
      else stuck_cycles++;
    end
  end

  // Receiver stalls, plus one long hold-off so the buffer fills and the input backs up.
  initial begin
    int mode;
    int runs;
    bit s;
    mode      = 0;
    runs      = 0;
    txt_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && numbers_accepted >= 80) begin
        holding_off = 1;
        txt_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        holding_off = 0;
        hold_done   = 1;
      end else begin
        if (runs % 40 == 0) mode = $urandom_range(0, 2);
        runs++;
        s = (mode != 0) && ($urandom_range(0, 1) == 1);
        txt_stall <= s;
        if (!s) repeat ($urandom_range(1, (mode == 0) ? 16 : 8)) @(negedge clk);
        else if ($urandom_range(0, 99) < 85) repeat ($urandom_range(1, 3)) @(negedge clk);
        else repeat ($urandom_range(10, 60)) @(negedge clk);
      end
    end
  end

  initial begin
    @(negedge clk);
    while (rst) @(posedge clk);
    while (stuck_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Timeout: nothing moved for %0d cycles, %0d characters still awaited",
             WATCHDOG_LIMIT, expected_chars.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    num_item_t item;
    int        idx;
    int        gap;
    int        send_mode;
    rst       = 1'b1;
    num_valid = 1'b0;
    num       = '0;
    send_mode = 0;

    for (idx = 0; idx < DIR_ROWS; idx++) begin
      item.cmd   = DIRECTED[idx].cmd;
      item.value = DIRECTED[idx].value;
      pending_nums.push_back(item);
      pending_texts.push_back(DIRECTED[idx].text);
    end
    for (idx = 0; idx < RANDOM_NUMBERS; idx++) begin
      item.cmd   = random_cmd();
      item.value = random_value();
      pending_nums.push_back(item);
      pending_texts.push_back('0);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (idx = 0; idx < pending_nums.size(); idx++) begin
      if (idx % 50 == 0) send_mode = $urandom_range(0, 2);
      gap = pick_gap(send_mode);
      if (gap > 0) begin
        num_valid <= 1'b0;
        num       <= {random_cmd(), 32'($urandom)};
        repeat (gap) @(negedge clk);
      end
      num_valid <= 1'b1;
      num       <= pending_nums[idx];
      @(posedge clk);
      while (num_stall) @(posedge clk);
      if (pending_texts[idx] != '0) expect_text(pending_texts[idx]);
      else predict_digits(pending_nums[idx]);
      numbers_accepted++;
      @(negedge clk);
    end
    num_valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d numbers (%0d directed edge cases, rest random) to %0d characters",
             numbers_accepted, DIR_ROWS, chars_checked);
    $display({"All radix codes, random gaps on both sides, %0d-cycle output hold-off; ",
              "%0d mismatches"}, HOLD_OFF_CYCLES, mismatches);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/utad_pkg.sv
src/utad_front.sv
src/utad_buffer.sv
src/utad_back.sv
src/unsigned_to_ascii_digits_core.sv
dv/tb_unsigned_to_ascii_digits_core.sv
